[hdl/c2e_pkg.sv]
// Package: shared types, constants and tables for the cube-map to equirect address block.
`timescale 1ns / 1ps
package c2e_pkg;

	typedef struct packed {
		logic [2:0]  face;
		logic [11:0] pix_x;
		logic [11:0] pix_y;
	} c2e_in_t;

	typedef struct packed {
		logic [12:0] src_x;
		logic [11:0] src_y;
		logic        coord_error;
	} c2e_out_t;

	localparam int MAX_FACE_SIZE_DEF = 4096;
	localparam int ANGLE_BITS_DEF    = 16;

	// quotient bits of pix*65536/face_size
	localparam int DIV_STEPS   = 16;
	localparam int CORDIC_ITERS = 24;
	localparam int CORDIC_W     = 36;
	localparam int DIR_W        = 18;
	localparam int IN_SHIFT     = 14;
	localparam int PROD_W       = DIR_W + 32;

	localparam logic signed [DIR_W-1:0] Q_ONE    = 18'sd32768;
	localparam logic signed [31:0]      GAIN_Q30 = 32'sd1768195367;
	localparam logic [31:0]             HALF_TURN  = 32'h8000_0000;
	localparam logic [31:0]             THREE_QTR  = 32'hC000_0000;

	// register index
	localparam logic [1:0] REG_FACE_SIZE   = 2'd0;
	localparam logic [1:0] REG_PANO_WIDTH  = 2'd1;
	localparam logic [1:0] REG_PANO_HEIGHT = 2'd2;
	localparam logic [1:0] REG_MIRROR      = 2'd3;

	localparam logic [12:0] FACE_SIZE_RST   = 13'd256;
	localparam logic [13:0] PANO_WIDTH_RST  = 14'd2048;
	localparam logic [12:0] PANO_HEIGHT_RST = 13'd1024;

	// face codes
	localparam logic [2:0] FACE_XP = 3'd0;
	localparam logic [2:0] FACE_XN = 3'd1;
	localparam logic [2:0] FACE_YP = 3'd2;
	localparam logic [2:0] FACE_YN = 3'd3;
	localparam logic [2:0] FACE_ZP = 3'd4;

	// atan(2^-i) in turns, 2^32 = one turn
	localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

endpackage

[hdl/c2e_divider.sv]
// Pipelined restoring divider: two lanes of pix*2^16/face_size, one quotient bit per stage.
`timescale 1ns / 1ps
module c2e_divider import c2e_pkg::*; #(
	parameter int FW     = 13,
	parameter int SIDE_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_in,
	input  logic [FW-1:0]     fs,
	input  logic [FW-1:0]     num_a,
	input  logic [FW-1:0]     num_b,
	input  logic [SIDE_W-1:0] side_in,
	output logic              valid_out,
	output logic [DIV_STEPS-1:0] quot_a,
	output logic [DIV_STEPS-1:0] quot_b,
	output logic [SIDE_W-1:0] side_out
);

	logic                 v_s    [DIV_STEPS];
	logic [FW-1:0]        rem_a_s[DIV_STEPS];
	logic [FW-1:0]        rem_b_s[DIV_STEPS];
	logic [DIV_STEPS-1:0] q_a_s  [DIV_STEPS];
	logic [DIV_STEPS-1:0] q_b_s  [DIV_STEPS];
	logic [SIDE_W-1:0]    side_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic                 v_p;
		logic [FW-1:0]        ra_p, rb_p;
		logic [DIV_STEPS-1:0] qa_p, qb_p;
		logic [SIDE_W-1:0]    sd_p;
		logic [FW:0]          ta, tb, da, db;
		logic                 ga, gb;

		if (k == 0) begin : g_first
			assign v_p  = valid_in;
			assign ra_p = num_a;
			assign rb_p = num_b;
			assign qa_p = '0;
			assign qb_p = '0;
			assign sd_p = side_in;
		end else begin : g_next
			assign v_p  = v_s[k-1];
			assign ra_p = rem_a_s[k-1];
			assign rb_p = rem_b_s[k-1];
			assign qa_p = q_a_s[k-1];
			assign qb_p = q_b_s[k-1];
			assign sd_p = side_s[k-1];
		end

		assign ta = {ra_p, 1'b0};
		assign tb = {rb_p, 1'b0};
		assign ga = ta >= {1'b0, fs};
		assign gb = tb >= {1'b0, fs};
		assign da = ta - {1'b0, fs};
		assign db = tb - {1'b0, fs};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_a_s[k] <= ga ? da[FW-1:0] : ta[FW-1:0];
				rem_b_s[k] <= gb ? db[FW-1:0] : tb[FW-1:0];
				q_a_s[k]   <= {qa_p[DIV_STEPS-2:0], ga};
				q_b_s[k]   <= {qb_p[DIV_STEPS-2:0], gb};
				side_s[k]  <= sd_p;
			end
		end
	end

	assign valid_out = v_s[DIV_STEPS-1];
	assign quot_a    = q_a_s[DIV_STEPS-1];
	assign quot_b    = q_b_s[DIV_STEPS-1];
	assign side_out  = side_s[DIV_STEPS-1];

endmodule

[hdl/c2e_cordic.sv]
// Pipelined vectoring CORDIC: angle in turns and gain-scaled magnitude of (x, y).
`timescale 1ns / 1ps
module c2e_cordic import c2e_pkg::*; #(
	parameter int W      = CORDIC_W,
	parameter int SIDE_W = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  logic signed [W-1:0] x_in,
	input  logic signed [W-1:0] y_in,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                valid_out,
	output logic [31:0]         angle,
	output logic signed [W-1:0] mag,
	output logic [SIDE_W-1:0]   side_out
);

	// pre-rotation into the right half plane
	logic                v_s0, zero_s0;
	logic signed [W-1:0] x_s0, y_s0;
	logic [31:0]         z_s0;
	logic [SIDE_W-1:0]   side_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s0 <= (x_in == '0) && (y_in == '0);
			x_s0    <= x_in[W-1] ? -x_in : x_in;
			y_s0    <= x_in[W-1] ? -y_in : y_in;
			z_s0    <= x_in[W-1] ? HALF_TURN : '0;
			side_s0 <= side_in;
		end
	end

	logic                v_s    [CORDIC_ITERS];
	logic                zero_s [CORDIC_ITERS];
	logic signed [W-1:0] x_s    [CORDIC_ITERS];
	logic signed [W-1:0] y_s    [CORDIC_ITERS];
	logic [31:0]         z_s    [CORDIC_ITERS];
	logic [SIDE_W-1:0]   side_s [CORDIC_ITERS];

	for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_iter
		logic                v_p, zr_p, up;
		logic signed [W-1:0] x_p, y_p, xs, ys;
		logic [31:0]         z_p;
		logic [SIDE_W-1:0]   sd_p;

		if (k == 0) begin : g_first
			assign v_p  = v_s0;
			assign zr_p = zero_s0;
			assign x_p  = x_s0;
			assign y_p  = y_s0;
			assign z_p  = z_s0;
			assign sd_p = side_s0;
		end else begin : g_next
			assign v_p  = v_s[k-1];
			assign zr_p = zero_s[k-1];
			assign x_p  = x_s[k-1];
			assign y_p  = y_s[k-1];
			assign z_p  = z_s[k-1];
			assign sd_p = side_s[k-1];
		end

		assign xs = x_p >>> k;
		assign ys = y_p >>> k;
		assign up = !y_p[W-1] && (y_p != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]    <= up ? x_p + ys : x_p - ys;
				y_s[k]    <= up ? y_p - xs : y_p + xs;
				z_s[k]    <= up ? z_p + ATAN_TURNS[k] : z_p - ATAN_TURNS[k];
				zero_s[k] <= zr_p;
				side_s[k] <= sd_p;
			end
		end
	end

	// origin: angle and magnitude are both zero
	assign valid_out = v_s[CORDIC_ITERS-1];
	assign angle     = zero_s[CORDIC_ITERS-1] ? '0 : z_s[CORDIC_ITERS-1];
	assign mag       = zero_s[CORDIC_ITERS-1] ? '0 : x_s[CORDIC_ITERS-1];
	assign side_out  = side_s[CORDIC_ITERS-1];

endmodule

[hdl/cubemap_to_equirect_address.sv]
// Top level: cube-map pixel to equirectangular source address pipeline.
//
//  channel | dir | handshake             | word
//  --------+-----+-----------------------+---------------------------------
//  in      | in  | in_valid / in_ready   | c2e_in_t  {face, pix_x, pix_y}
//  out     | out | out_valid / out_ready | c2e_out_t {src_x, src_y, coord_error}
//  cfg     | in  | cfg_wen               | cfg_index, cfg_wdata (write only)
//
// One word per cycle sustained while out_ready drains the output register;
// 69 register stages: 16 divider stages, 1 direction stage,
// 2 x 25 CORDIC stages, 2 scale stages.
// The whole pipeline advances together; it holds only when the output
// register is full and out_ready is low, so nothing is lost or repeated.
// Reset clears all stage valid bits and loads register defaults.
// Registers must be written only while the pipeline is empty (not enforced).
`timescale 1ns / 1ps
module cubemap_to_equirect_address import c2e_pkg::*; #(
	parameter int MAX_FACE_SIZE = MAX_FACE_SIZE_DEF,
	parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  c2e_in_t     in_word,
	output logic        out_valid,
	input  logic        out_ready,
	output c2e_out_t    out_word,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_wdata
);

	localparam int FW = $clog2(MAX_FACE_SIZE + 1);
	localparam int AB = ANGLE_BITS;
	localparam int CW = CORDIC_W;

	// ---------------- configuration registers ----------------
	logic [12:0] face_size_q;
	logic [13:0] pano_width_q;
	logic [12:0] pano_height_q;
	logic        mirror_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_size_q   <= FACE_SIZE_RST;
			pano_width_q  <= PANO_WIDTH_RST;
			pano_height_q <= PANO_HEIGHT_RST;
			mirror_q      <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_FACE_SIZE:   face_size_q   <= cfg_wdata[12:0];
				REG_PANO_WIDTH:  pano_width_q  <= cfg_wdata;
				REG_PANO_HEIGHT: pano_height_q <= cfg_wdata[12:0];
				REG_MIRROR:      mirror_q      <= cfg_wdata[0];
			endcase
		end
	end

	// global advance: the output register is free or being drained
	logic en;
	logic valid_s3;
	assign en       = !valid_s3 || out_ready;
	assign in_ready = en;

	// ---------------- input: clamp size, range check ----------------
	logic [FW-1:0] fs;
	logic          err_in;

	assign fs = (32'(face_size_q) > 32'(MAX_FACE_SIZE)) ? FW'(MAX_FACE_SIZE)
	                                                    : FW'(face_size_q);
	// face_size of zero always lands here
	assign err_in = (32'(in_word.pix_x) >= 32'(fs)) || (32'(in_word.pix_y) >= 32'(fs));

	logic                 dv_valid, dv_err;
	logic [DIV_STEPS-1:0] q_x, q_y;
	logic [2:0]           dv_face;

	c2e_divider #(.FW(FW), .SIDE_W(4)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (in_valid && in_ready),
		.fs        (fs),
		.num_a     (FW'(in_word.pix_x)),
		.num_b     (FW'(in_word.pix_y)),
		.side_in   ({err_in, in_word.face}),
		.valid_out (dv_valid),
		.quot_a    (q_x),
		.quot_b    (q_y),
		.side_out  ({dv_err, dv_face})
	);

	// ---------------- s1: u, v, face direction, dz gain product ----------------
	logic signed [DIR_W-1:0] u, v, dx, dy, dz;

	assign u = $signed({2'b00, q_x}) - Q_ONE;
	assign v = $signed({2'b00, q_y}) - Q_ONE;

	always_comb begin
		case (dv_face)
			FACE_XP: begin dx = -u;     dy = Q_ONE;  dz = -v;     end
			FACE_XN: begin dx = u;      dy = -Q_ONE; dz = -v;     end
			FACE_YP: begin dx = v;      dy = u;      dz = Q_ONE;  end
			FACE_YN: begin dx = -v;     dy = u;      dz = -Q_ONE; end
			FACE_ZP: begin dx = Q_ONE;  dy = u;      dz = -v;     end
			// Z- and the two unused codes
			default: begin dx = -Q_ONE; dy = -u;     dz = -v;     end
		endcase
	end

	logic                     valid_s1, err_s1;
	logic signed [CW-1:0]     x_s1, y_s1;
	logic signed [PROD_W-1:0] dzp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s1 <= dv_err;
			x_s1   <= CW'(dx) <<< IN_SHIFT;
			y_s1   <= CW'(dy) <<< IN_SHIFT;
			// dz*2^14*gain/2^30 == dz*gain/2^16
			dzp_s1 <= PROD_W'(dz) * PROD_W'(GAIN_Q30);
		end
	end

	logic signed [CW-1:0] dzk;
	assign dzk = CW'(dzp_s1 >>> 16);

	// ---------------- longitude CORDIC ----------------
	logic                 c1_valid, c1_err;
	logic [31:0]          phi;
	logic signed [CW-1:0] hmag, c1_dzk;

	c2e_cordic #(.W(CW), .SIDE_W(CW + 1)) u_cordic_lon (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (valid_s1),
		.x_in      (x_s1),
		.y_in      (y_s1),
		.side_in   ({err_s1, dzk}),
		.valid_out (c1_valid),
		.angle     (phi),
		.mag       (hmag),
		.side_out  ({c1_err, c1_dzk})
	);

	// ---------------- polar CORDIC: atan2(horizontal, dz) ----------------
	logic                 c2_valid, c2_err;
	logic [31:0]          theta, c2_phi;
	logic signed [CW-1:0] c2_mag;

	c2e_cordic #(.W(CW), .SIDE_W(33)) u_cordic_pol (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (c1_valid),
		.x_in      (c1_dzk),
		.y_in      (hmag),
		.side_in   ({c1_err, phi}),
		.valid_out (c2_valid),
		.angle     (theta),
		.mag       (c2_mag),
		.side_out  ({c2_err, c2_phi})
	);

	// ---------------- s2: s, t and scale products ----------------
	logic [31:0] s32, theta_c;
	logic [AB:0] sa, sm, ta;
	logic [13:0] wm;
	logic [12:0] hm;

	assign s32 = c2_phi + HALF_TURN;
	assign sa  = {1'b0, s32[31 -: AB]};
	assign sm  = mirror_q ? (AB+1)'((AB+1)'(1) << AB) - sa : sa;

	// CORDIC overshoot: slightly negative wraps to zero, past half turn to half
	always_comb begin
		if (theta >= THREE_QTR) begin
			theta_c = '0;
		end else if (theta > HALF_TURN) begin
			theta_c = HALF_TURN;
		end else begin
			theta_c = theta;
		end
	end
	assign ta = theta_c[31 -: AB+1];

	assign wm = (pano_width_q  != '0) ? pano_width_q  - 14'd1 : '0;
	assign hm = (pano_height_q != '0) ? pano_height_q - 13'd1 : '0;

	logic             valid_s2, err_s2;
	logic [AB+14:0]   px_s2;
	logic [AB+13:0]   py_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= c2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s2 <= c2_err;
			px_s2  <= (AB+15)'(sm) * (AB+15)'(wm);
			py_s2  <= (AB+14)'(ta) * (AB+14)'(hm);
		end
	end

	// ---------------- s3: truncate, saturate, output register ----------------
	logic [14:0] sx;
	logic [13:0] sy;
	assign sx = px_s2[AB+14:AB];
	assign sy = py_s2[AB+13:AB];

	c2e_out_t res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3.coord_error <= err_s2;
			res_s3.src_x <= err_s2 ? '0 : ((sx > 15'd8191) ? 13'h1FFF : sx[12:0]);
			res_s3.src_y <= err_s2 ? '0 : ((sy > 14'd4095) ? 12'hFFF : sy[11:0]);
		end
	end

	assign out_valid = valid_s3;
	assign out_word  = res_s3;

	// ---------------- assertions ----------------
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.coord_error |-> out_word.src_x == '0 && out_word.src_y == '0)
		else $error("coord_error word carries a nonzero address");

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.coord_error |-> 14'(out_word.src_x) <= wm)
		else $error("src_x beyond source width minus one");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.coord_error |-> 13'(out_word.src_y) <= hm)
		else $error("src_y beyond source height minus one");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(valid_s2) && $stable(px_s2) && $stable(py_s2))
		else $error("pipeline moved during a stall");

	// c2_mag is the polar radius; unused beyond the second CORDIC
	a_mag_sign: assert property (@(posedge clk) disable iff (!arst_n)
		c2_valid |-> !c2_mag[CW-1])
		else $error("polar CORDIC magnitude negative");

endmodule
